// ----- src/mbet_pkg.sv -----
// ----------------------------------------------------------------------------
// mbet_pkg: shared types and constants of the escape-time unit
// Field widths, register indices, FSM state codes and the bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int COORD_W    = 64;           // c and z components
  localparam int HALF_W     = COORD_W / 2;  // operand slice per multiplier
  localparam int PROD_W     = 2 * COORD_W;  // full product width
  localparam int DWELL_W    = 16;
  localparam int LIMIT_W    = 18;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = CFG_IDX_W'(1);

  localparam logic [DWELL_W-1:0] MAX_ITER_RST     = DWELL_W'(3000);
  localparam logic [LIMIT_W-1:0] ESCAPE_LIMIT_RST = LIMIT_W'(250000);

  // four partial products per 64x64 product, then a drain step
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(4);

  typedef enum logic [1:0] {
    PP_LL,
    PP_LH,
    PP_HL,
    PP_HH
  } pp_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_CHK,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    load;      // capture point, clear z and count
    logic    abs_en;    // take |x|, |y| for the multipliers
    logic    pp_en;     // issue one partial product
    pp_sel_t pp_sel;
    logic    acc_en;    // fold the last partial product in
    logic    chk_en;    // magnitude test and difference terms
    logic    upd_en;    // new z, count up
    logic    out_load;  // result into the output register
  } cmd_t;

  typedef struct packed {
    logic n_limit;      // count has reached max_iter
    logic stop;         // magnitude test fired
  } status_t;

endpackage

// ----- src/mbet_point_if.sv -----
// ----------------------------------------------------------------------------
// mbet_point_if: input channel carrying one complex point
// Valid/ready handshake with the real and imaginary parts of c.
// ----------------------------------------------------------------------------
interface mbet_point_if import mbet_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_re;
  logic signed [COORD_W-1:0] point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

// ----- src/mbet_result_if.sv -----
// ----------------------------------------------------------------------------
// mbet_result_if: result channel
// Valid/ready handshake with the dwell count and the escape flag.
// ----------------------------------------------------------------------------
interface mbet_result_if import mbet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DWELL_W-1:0] dwell;
  logic               escaped;

  modport source (output valid, output dwell, output escaped, input ready);
  modport sink   (input valid, input dwell, input escaped, output ready);
endinterface

// ----- src/mbet_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mbet_cfg_if: configuration write channel
// Valid/ready handshake with a register index and write data.
// ----------------------------------------------------------------------------
interface mbet_cfg_if import mbet_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/mbet_datapath.sv -----
// ----------------------------------------------------------------------------
// mbet_datapath: z registers, multipliers, accumulators and count
// Three 32x32 multipliers build |x|^2, |y|^2 and |x*y| from four partial
// products each; the magnitude test and the z update follow.
// ----------------------------------------------------------------------------
module mbet_datapath import mbet_pkg::*; #(
  parameter int FRAC_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_idx,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_W-1:0] point_re,
  input  logic signed [COORD_W-1:0] point_im,
  output logic [DWELL_W-1:0]        dwell,
  output logic                      escaped
);

  logic [DWELL_W-1:0]        max_iter_r;
  logic [LIMIT_W-1:0]        escape_limit_r;
  logic signed [COORD_W-1:0] cre_r, cim_r, x_r, y_r;
  logic [COORD_W-1:0]        ax_r, ay_r;
  logic                      neg_xy_r;
  logic [COORD_W-1:0]        pp_xx_r, pp_yy_r, pp_xy_r;
  pp_sel_t                   acc_sel_r;
  logic [PROD_W-1:0]         acc_xx_r, acc_yy_r, acc_xy_r;
  logic signed [PROD_W-1:0]  diff_r, xys_r;
  logic                      stop_r;
  logic [DWELL_W-1:0]        n_r;
  logic [DWELL_W-1:0]        dwell_r;
  logic                      escaped_r;

  logic [HALF_W-1:0]         ax_part, ay_part, bx_part, by_part;
  logic [PROD_W-1:0]         sum_w, mag_w;
  logic signed [PROD_W-1:0]  nx_w, ny_w;

  function automatic logic [PROD_W-1:0] place(input logic [COORD_W-1:0] p,
                                              input pp_sel_t s);
    logic [PROD_W-1:0] r;
    r = PROD_W'(p);
    case (s) inside
      PP_LL:        place = r;
      PP_LH, PP_HL: place = r << HALF_W;
      PP_HH:        place = r << COORD_W;
      default:      place = r;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-COORD_W:0] top;
    top = v[PROD_W-1:COORD_W-1];
    if ((&top) || !(|top))
      sat = v[COORD_W-1:0];
    else if (v[PROD_W-1])
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    else
      sat = {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r     <= MAX_ITER_RST;
      escape_limit_r <= ESCAPE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_ITER:     max_iter_r     <= cfg_data[DWELL_W-1:0];
        REG_ESCAPE_LIMIT: escape_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // operand slices: first factor by sel[1], second by sel[0]
  always_comb begin
    ax_part = cmd.pp_sel[1] ? ax_r[COORD_W-1:HALF_W] : ax_r[HALF_W-1:0];
    ay_part = cmd.pp_sel[1] ? ay_r[COORD_W-1:HALF_W] : ay_r[HALF_W-1:0];
    bx_part = cmd.pp_sel[0] ? ax_r[COORD_W-1:HALF_W] : ax_r[HALF_W-1:0];
    by_part = cmd.pp_sel[0] ? ay_r[COORD_W-1:HALF_W] : ay_r[HALF_W-1:0];
  end

  // c is sign-extended by a size cast; $signed keeps the shifts arithmetic
  always_comb begin
    sum_w = acc_xx_r + acc_yy_r;
    mag_w = sum_w >> (2 * FRAC_BITS);
    nx_w  = ($signed(diff_r) >>> FRAC_BITS) + PROD_W'(cre_r);
    ny_w  = ($signed(xys_r) >>> (FRAC_BITS - 1)) + PROD_W'(cim_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cre_r <= point_re;
      cim_r <= point_im;
    end
    if (cmd.abs_en) begin
      ax_r     <= x_r[COORD_W-1] ? (~x_r + 1'b1) : x_r;
      ay_r     <= y_r[COORD_W-1] ? (~y_r + 1'b1) : y_r;
      neg_xy_r <= x_r[COORD_W-1] ^ y_r[COORD_W-1];
    end
    if (cmd.pp_en) begin
      pp_xx_r   <= ax_part * bx_part;
      pp_yy_r   <= ay_part * by_part;
      pp_xy_r   <= ax_part * by_part;
      acc_sel_r <= cmd.pp_sel;
    end
    if (cmd.acc_en) begin
      if (acc_sel_r == PP_LL) begin
        acc_xx_r <= place(pp_xx_r, acc_sel_r);
        acc_yy_r <= place(pp_yy_r, acc_sel_r);
        acc_xy_r <= place(pp_xy_r, acc_sel_r);
      end else begin
        acc_xx_r <= acc_xx_r + place(pp_xx_r, acc_sel_r);
        acc_yy_r <= acc_yy_r + place(pp_yy_r, acc_sel_r);
        acc_xy_r <= acc_xy_r + place(pp_xy_r, acc_sel_r);
      end
    end
    if (cmd.chk_en) begin
      diff_r <= acc_xx_r - acc_yy_r;
      xys_r  <= neg_xy_r ? (~acc_xy_r + 1'b1) : acc_xy_r;
    end
    if (cmd.out_load) begin
      dwell_r   <= n_r;
      escaped_r <= stop_r;
    end
  end

  // z, count and stop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
      n_r    <= '0;
      x_r    <= '0;
      y_r    <= '0;
    end else if (cmd.load) begin
      stop_r <= 1'b0;
      n_r    <= '0;
      x_r    <= '0;
      y_r    <= '0;
    end else begin
      if (cmd.chk_en)
        stop_r <= (mag_w >= PROD_W'(escape_limit_r));
      if (cmd.upd_en) begin
        x_r <= sat(nx_w);
        y_r <= sat(ny_w);
        n_r <= n_r + 1'b1;
      end
    end
  end

  assign status.n_limit = (n_r >= max_iter_r);
  assign status.stop    = stop_r;
  assign dwell          = dwell_r;
  assign escaped        = escaped_r;

  a_upd_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_en |=> (n_r == $past(n_r) + 1'b1))
    else $error("count did not step on update");

  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (x_r == '0 && y_r == '0 && n_r == '0 && !stop_r))
    else $error("z not cleared on new point");

endmodule

// ----- src/mbet_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbet_ctrl: iteration sequencer
// Walks test, multiply, check and update per iteration and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module mbet_ctrl import mbet_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid)              state_nxt = ST_TEST;
      ST_TEST: state_nxt = status.n_limit ? ST_DONE : ST_MUL;
      ST_MUL:  if (step_r == MUL_LAST)    state_nxt = ST_CHK;
      ST_CHK:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = status.stop ? ST_DONE : ST_TEST;
      ST_DONE: if (out_free)              state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs; no item is taken while reset is held
  always_comb begin
    cmd          = '0;
    cmd.pp_sel   = pp_sel_t'(step_r[1:0]);
    in_ready     = 1'b0;
    step_nxt     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
      end
      ST_TEST: cmd.abs_en = 1'b1;
      ST_MUL: begin
        cmd.pp_en  = (step_r != MUL_LAST);
        cmd.acc_en = (step_r != '0);
        step_nxt   = step_r + 1'b1;
      end
      ST_CHK:  cmd.chk_en   = 1'b1;
      ST_UPD:  cmd.upd_en   = !status.stop;
      ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (step_r <= MUL_LAST))
    else $error("multiply step out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("result overwrote a waiting item");

endmodule

// ----- src/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time count for one complex point
// Iterates z = z*z + c from z = 0 in saturating fixed point and reports the
// iteration count and whether |z|^2 reached the escape limit.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one item per point, c = point_re + i*point_im, signed fixed
//            point with FRAC_BITS fraction bits. Taken only while idle.
//   out_ch : one item per point, dwell and escaped flag.
//   cfg_ch : index 0 = max_iter, index 1 = escape_limit; other indices are
//            ignored. Always ready; write only while no point is in flight.
// Iteration
//   Each iteration runs an operand step, four partial products plus a
//   drain on three shared 32x32 multipliers, a check and an update. The
//   next point is accepted once the sequencer is back in idle, after the
//   result has gone into the output register.
// Reset
//   rst_n (synchronous) returns max_iter to 3000, escape_limit to 250000 and
//   empties the output register.
// Stall
//   A finished result waits in the output register; a second finished
//   result holds in the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbet_pkg::*; #(
  parameter int FRAC_BITS = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  mbet_point_if.sink    in_ch,
  mbet_result_if.source out_ch,
  mbet_cfg_if.sink      cfg_ch
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ch.ready = 1'b1;

  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mbet_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .point_re (in_ch.point_re),
    .point_im (in_ch.point_im),
    .dwell    (out_ch.dwell),
    .escaped  (out_ch.escaped)
  );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the escape-time unit
// Feeds complex points through the input channel, works out dwell and the
// escape flag for each accepted point with a 128-bit fixed-point predictor,
// and compares every result item in order. Register settings are changed
// between phases while the unit is idle; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mbet_pkg::*;

  localparam int FRAC = 48;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int          SETTLE_CYCLES = 32;

  // indices outside the register map, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] ONE       = 64'sd1 <<< FRAC;

  typedef struct packed {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } point_t;

  typedef struct packed {
    logic [DWELL_W-1:0] dwell;
    logic               escaped;
  } escape_t;

  logic clk = 1'b0;
  logic rst_n;

  mbet_point_if  in_ch();
  mbet_result_if out_ch();
  mbet_cfg_if    cfg_ch();

  mandelbrot_escape_time #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the two registers; only touched while the unit is idle.
  logic [DWELL_W-1:0] iter_cap;
  logic [LIMIT_W-1:0] mag_bound;

  point_t  point_q[$];     // points still to be offered
  escape_t dwell_q[$];     // predicted results, oldest first

  logic        point_taken = 1'b0;
  int          idle_pct    = 18;   // chance of a gap/stall per cycle, in percent
  int unsigned cycle_count = 0;
  int          error_count = 0;
  int          points_sent = 0;
  int          cfg_writes  = 0;
  int          escaped_seen = 0;
  int          inside_seen  = 0;
  int          deepest_dwell = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic signed [COORD_W-1:0] clamp_coord(
    input logic signed [PROD_W-1:0] v
  );
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // z <- z*z + c from z = 0. Squares and the cross term are exact 128-bit
  // products; the magnitude test uses the integer part of |z|^2, taken as
  // unsigned so that two full-scale squares cannot wrap.
  function automatic escape_t escape_time(
    input logic signed [COORD_W-1:0] c_re,
    input logic signed [COORD_W-1:0] c_im,
    input logic [DWELL_W-1:0]        cap,
    input logic [LIMIT_W-1:0]        bound
  );
    logic signed [COORD_W-1:0] zr, zi;
    logic signed [PROD_W-1:0]  wide_r, wide_i, sq_r, sq_i, prod_ri, next_r, next_i;
    logic [PROD_W-1:0]         mag;
    int unsigned               n;
    escape_t                   res;
    zr   = '0;
    zi   = '0;
    sq_r = '0;
    sq_i = '0;
    n    = 0;
    while (n < cap) begin
      mag = sq_r + sq_i;
      mag = mag >> (2 * FRAC);
      if (mag >= bound) break;
      wide_r  = zr;
      wide_i  = zi;
      prod_ri = wide_r * wide_i;
      next_r  = ((sq_r - sq_i) >>> FRAC) + c_re;
      next_i  = (prod_ri >>> (FRAC - 1)) + c_im;
      zr      = clamp_coord(next_r);
      zi      = clamp_coord(next_i);
      wide_r  = zr;
      wide_i  = zi;
      sq_r    = wide_r * wide_r;
      sq_i    = wide_i * wide_i;
      n++;
    end
    res.dwell   = DWELL_W'(n);
    res.escaped = (n < cap);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Point driver: new item on the falling edge, acceptance seen on the rising
  // edge. valid stays up across back-to-back items.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      dwell_q.push_back(escape_time(in_ch.point_re, in_ch.point_im, iter_cap, mag_bound));
      void'(point_q.pop_front());
      points_sent++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || point_taken) begin
      if (point_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_ch.valid    <= 1'b1;
        in_ch.point_re <= point_q[0].re;
        in_ch.point_im <= point_q[0].im;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    escape_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dwell_q.size() == 0) begin
        $display("%0t: result with no point outstanding: dwell %0d escaped %0b",
                 $time, out_ch.dwell, out_ch.escaped);
        error_count++;
      end else begin
        want = dwell_q.pop_front();
        if (out_ch.dwell !== want.dwell) begin
          $display("%0t: dwell mismatch, expected %0d, got %0d",
                   $time, want.dwell, out_ch.dwell);
          error_count++;
        end
        if (out_ch.escaped !== want.escaped) begin
          $display("%0t: escaped mismatch, expected %0b, got %0b",
                   $time, want.escaped, out_ch.escaped);
          error_count++;
        end
        if (want.escaped) escaped_seen++;
        else inside_seen++;
        if (want.dwell > deepest_dwell) deepest_dwell = want.dwell;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timed out, %0d points queued, %0d results outstanding",
               $time, point_q.size(), dwell_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_point(input logic signed [COORD_W-1:0] re,
                             input logic signed [COORD_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    point_q.push_back(p);
  endtask

  // Mostly points in and around the set, where dwell varies; the rest have
  // arbitrary bit patterns in one or both parts so every input bit gets exercised.
  task automatic queue_random_point();
    int                        whole_re, whole_im;
    logic signed [COORD_W-1:0] frac_re, frac_im;
    whole_re = $urandom_range(0, 4);
    whole_re = whole_re - 3;                  // -3 .. 1
    whole_im = $urandom_range(0, 3);
    whole_im = whole_im - 2;                  // -2 .. 1
    frac_re  = {16'h0, 16'($urandom), $urandom};
    frac_im  = {16'h0, 16'($urandom), $urandom};
    case ($urandom_range(0, 9))
      0:       queue_point({$urandom, $urandom}, {$urandom, $urandom});
      1:       queue_point({$urandom, $urandom}, ONE * whole_im + frac_im);
      default: queue_point(ONE * whole_re + frac_re, ONE * whole_im + frac_im);
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MAX_ITER:     iter_cap  = value[DWELL_W-1:0];
      REG_ESCAPE_LIMIT: mag_bound = value[LIMIT_W-1:0];
      default: ;                              // outside the map, no effect
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Every point answers with exactly one item, so an empty prediction store
  // with nothing left to send means the unit is idle again.
  task automatic wait_idle();
    while (point_q.size() != 0 || dwell_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.point_re = '0;
    in_ch.point_im = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    iter_cap       = MAX_ITER_RST;
    mag_bound      = ESCAPE_LIMIT_RST;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: two points that never leave, full-scale corners, a
    // short orbit and orbits that overflow the z format and get clamped.
    queue_point('0, '0);
    queue_point(-ONE, '0);                    // period-two orbit 0, -1
    queue_point(COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN);
    queue_point(COORD_MIN, COORD_MAX);
    queue_point('0, COORD_MIN);
    queue_point(ONE, '0);                     // 1, 2, 5, 26, 677
    queue_point(ONE * 300, '0);               // x squared overflows, clamped high
    queue_point('0, ONE * 300);               // x goes below the range, clamped low
    queue_point(-ONE * 300, -ONE * 300);      // y overflows through the cross term
    wait_idle();

    // No iterations at all, with and without a zero escape bound
    write_reg(REG_MAX_ITER, '0);
    queue_point('0, '0);
    queue_point(COORD_MAX, COORD_MAX);
    wait_idle();
    write_reg(REG_ESCAPE_LIMIT, '0);
    queue_point(ONE, '0);
    wait_idle();

    // Zero bound with one iteration allowed: the first test stops it
    write_reg(REG_MAX_ITER, CFG_DATA_W'(1));
    queue_point('0, '0);
    queue_point(COORD_MIN, COORD_MIN);
    wait_idle();

    // Smallest useful bound; with one iteration the magnitude is never
    // tested after it, so even a far point counts as inside
    write_reg(REG_ESCAPE_LIMIT, CFG_DATA_W'(4));
    queue_point('0, '0);
    queue_point(ONE * 2, '0);
    queue_point(COORD_MIN, '0);
    wait_idle();
    write_reg(REG_MAX_ITER, CFG_DATA_W'(2));
    queue_point(ONE * 2, '0);                 // |z|^2 hits the bound exactly
    queue_point(ONE, ONE);                    // reaches the cap un-escaped
    wait_idle();

    // Largest settings, only with points that escape early; writes outside
    // the register map must leave them alone
    write_reg(REG_MAX_ITER, CFG_DATA_W'(65535));
    write_reg(REG_ESCAPE_LIMIT, CFG_DATA_W'(262143));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    queue_point(ONE, '0);
    queue_point(ONE * 600, '0);
    queue_point(COORD_MAX, COORD_MIN);
    queue_point(-ONE * 600, ONE * 600);
    wait_idle();

    // Random points, first a stretch with neither side idling
    idle_pct = 0;
    write_reg(REG_MAX_ITER, CFG_DATA_W'(100));
    write_reg(REG_ESCAPE_LIMIT, CFG_DATA_W'(4));
    repeat (70) queue_random_point();
    wait_idle();

    // Upper data bits set: only the register width must be kept
    idle_pct = 18;
    write_reg(REG_MAX_ITER, {16'hA5A5, 16'd40});
    write_reg(REG_ESCAPE_LIMIT, {14'h2AAA, 18'd16});
    repeat (70) queue_random_point();
    wait_idle();

    // Random settings
    repeat (3) begin
      write_reg(REG_MAX_ITER, CFG_DATA_W'($urandom_range(20, 200)));
      write_reg(REG_ESCAPE_LIMIT, CFG_DATA_W'($urandom_range(4, 262143)));
      repeat (20) queue_random_point();
      wait_idle();
    end

    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d points under %0d register writes: %0d escaped, %0d stayed in",
             points_sent, cfg_writes, escaped_seen, inside_seen);
    $display("Deepest dwell %0d, %0d mismatches, %0d cycles", deepest_dwell,
             error_count, cycle_count);
    if (error_count == 0 && dwell_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
